// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on clk, off while reset is asserted
`define OBDRFP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent check that a condition never holds
`define OBDRFP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/obdrfp_pkg.sv =====
package obdrfp_pkg;

	// Field widths
	localparam int ByteW     = 8;
	localparam int PosW      = 7;
	localparam int LenFieldW = 6;
	localparam int GapW      = 16;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 16;

	// Input command codes
	localparam logic CmdByte = 1'b0;
	localparam logic CmdTick = 1'b1;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgGapTimeout     = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgMatchedService = 1'b1;

	// Configuration reset values
	localparam logic [GapW-1:0]  GapTimeoutRst     = 16'd20;
	localparam logic [ByteW-1:0] MatchedServiceRst = 8'h41;

	// Frame layout
	localparam logic [LenFieldW-1:0] LenMask       = 6'h3F;
	localparam logic [PosW-1:0]      FrameOverhead = 7'd4;
	localparam logic [PosW-1:0]      HdrLen        = 7'd3;
	localparam logic [PosW-1:0]      SvcPos        = 7'd3;
	localparam logic [PosW-1:0]      PidPos        = 7'd4;
	localparam logic [PosW-1:0]      MaxPos        = 7'd66;

	typedef struct packed {
		logic [GapW-1:0]  gap_timeout_ticks;
		logic [ByteW-1:0] matched_service;
	} cfg_t;

	typedef struct packed {
		logic [ByteW-1:0] frame_byte;
		logic [PosW-1:0]  position;
		logic             frame_end;
		logic             checksum_ok;
		logic             service_match;
		logic [ByteW-1:0] pid;
		logic [PosW-1:0]  frame_length;
		logic             restarted;
	} result_t;

endpackage

// ===== rtl/core/obdrfp_rx_if.sv =====
interface obdrfp_rx_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [obdrfp_pkg::ByteW-1:0]  data_byte;

	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

// ===== rtl/core/obdrfp_res_if.sv =====
interface obdrfp_res_if;
	logic                         valid;
	logic                         ready;
	logic [obdrfp_pkg::ByteW-1:0] frame_byte;
	logic [obdrfp_pkg::PosW-1:0]  position;
	logic                         frame_end;
	logic                         checksum_ok;
	logic                         service_match;
	logic [obdrfp_pkg::ByteW-1:0] pid;
	logic [obdrfp_pkg::PosW-1:0]  frame_length;
	logic                         restarted;

	modport source (
		output valid, frame_byte, position, frame_end, checksum_ok, service_match,
			pid, frame_length, restarted,
		input ready
	);
	modport sink (
		input valid, frame_byte, position, frame_end, checksum_ok, service_match,
			pid, frame_length, restarted,
		output ready
	);
endinterface

// ===== rtl/core/obdrfp_cfg_if.sv =====
interface obdrfp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [obdrfp_pkg::CfgIdxW-1:0]  index;
	logic [obdrfp_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/obdrfp_cfg_regs.sv =====
module obdrfp_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	obdrfp_cfg_if.sink           cfg,
	output obdrfp_pkg::cfg_t     regs
);

	obdrfp_pkg::cfg_t regs_q;

	// Take every write request at once
	assign cfg.ready = 1'b1;

	// Update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gap_timeout_ticks <= obdrfp_pkg::GapTimeoutRst;
			regs_q.matched_service   <= obdrfp_pkg::MatchedServiceRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				obdrfp_pkg::CfgGapTimeout: begin
					regs_q.gap_timeout_ticks <= cfg.data;
				end
				obdrfp_pkg::CfgMatchedService: begin
					regs_q.matched_service <= cfg.data[obdrfp_pkg::ByteW-1:0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/core/obdrfp_frame_core.sv =====
`include "assert_macros.svh"

module obdrfp_frame_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          command,
	input  logic [obdrfp_pkg::ByteW-1:0]  data_byte,
	input  obdrfp_pkg::cfg_t              cfg,
	output obdrfp_pkg::result_t           res
);

	localparam int ByteW = obdrfp_pkg::ByteW;
	localparam int PosW  = obdrfp_pkg::PosW;
	localparam int LenW  = obdrfp_pkg::LenFieldW;
	localparam int GapW  = obdrfp_pkg::GapW;

	logic            in_body_q;
	logic [PosW-1:0] byte_count_q;
	logic [ByteW-1:0] sum_q;
	logic [LenW-1:0] len_q;
	logic [ByteW-1:0] svc_q;
	logic [ByteW-1:0] pid_q;
	logic [GapW-1:0] gap_q;

	logic            late;
	logic            in_body_eff;
	logic [PosW-1:0] pos;
	logic [ByteW-1:0] sum_eff;
	logic [LenW-1:0] len_eff;
	logic [ByteW-1:0] svc_eff;
	logic [ByteW-1:0] pid_eff;
	logic [PosW-1:0] total;
	logic [PosW:0]   pos_inc;
	logic            frame_end;
	logic            sum_ok;
	logic            is_byte;

	// Drop the partial frame when the gap has run out
	assign late        = gap_q >= cfg.gap_timeout_ticks;
	assign in_body_eff = late ? 1'b0 : in_body_q;
	assign pos         = late ? '0 : byte_count_q;
	assign sum_eff     = late ? '0 : sum_q;

	// Capture header, service and pid fields at their positions
	assign len_eff = (pos == '0) ? (data_byte[LenW-1:0] & obdrfp_pkg::LenMask) : len_q;
	assign svc_eff = (pos == obdrfp_pkg::SvcPos) ? data_byte : (late ? '0 : svc_q);
	assign pid_eff = (pos == obdrfp_pkg::PidPos) ? data_byte : (late ? '0 : pid_q);

	// Detect the last byte by length and check the sum
	assign total     = PosW'(len_eff) + obdrfp_pkg::FrameOverhead;
	assign pos_inc   = {1'b0, pos} + (PosW+1)'(1);
	assign frame_end = in_body_eff && (pos_inc == {1'b0, total});
	assign sum_ok    = frame_end && (data_byte == sum_eff);

	assign res.frame_byte    = data_byte;
	assign res.position      = pos;
	assign res.frame_end     = frame_end;
	assign res.checksum_ok   = sum_ok;
	assign res.service_match = sum_ok && (svc_eff == cfg.matched_service);
	assign res.pid           = pid_eff;
	assign res.frame_length  = total;
	assign res.restarted     = late && (byte_count_q != '0);

	assign is_byte = step && (command == obdrfp_pkg::CmdByte);

	// Advance the frame state on each received byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q    <= 1'b0;
			byte_count_q <= '0;
			sum_q        <= '0;
			len_q        <= '0;
			svc_q        <= '0;
			pid_q        <= '0;
		end else if (is_byte) begin
			if (frame_end) begin
				in_body_q    <= 1'b0;
				byte_count_q <= '0;
				sum_q        <= '0;
				len_q        <= '0;
				svc_q        <= '0;
				pid_q        <= '0;
			end else begin
				in_body_q    <= pos_inc >= {1'b0, obdrfp_pkg::HdrLen};
				byte_count_q <= pos_inc[PosW-1:0];
				sum_q        <= sum_eff + data_byte;
				len_q        <= len_eff;
				svc_q        <= svc_eff;
				pid_q        <= pid_eff;
			end
		end
	end

	// Count ticks since the last byte, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (is_byte) begin
			gap_q <= '0;
		end else if (step && gap_q != '1) begin
			gap_q <= gap_q + GapW'(1);
		end
	end

	`OBDRFP_ASSERT(a_count_range, clk, arst_n, byte_count_q <= obdrfp_pkg::MaxPos, "byte count past longest frame")
	`OBDRFP_ASSERT(a_body_tracks_count, clk, arst_n, in_body_q == (byte_count_q >= obdrfp_pkg::HdrLen), "in_body out of step with count")
	`OBDRFP_ASSERT(a_end_clears, clk, arst_n, is_byte && frame_end |=> byte_count_q == '0 && sum_q == '0, "frame end did not clear state")
	`OBDRFP_ASSERT_NEVER(a_match_needs_ok, clk, arst_n, res.service_match && !res.checksum_ok, "service match without good checksum")

endmodule

// ===== rtl/core/obd_response_frame_parser_unit.sv =====
// OBD response frame parser. Each request on rx is either a received byte (command 0) or a
// one-millisecond tick (command 1). Every byte yields one result on parsed, carrying the
// byte, its position in the frame, the frame length from the format byte, the pid (byte 4)
// and, on the last byte, checksum and service-match flags; ticks yield nothing and only
// advance the inter-byte gap counter. A byte arriving after gap_timeout_ticks or more ticks
// drops the partial frame first and flags restarted. The block takes one request per clock
// cycle unless a byte waits for parsed to take the last result; a byte's result passes through
// one input register and one result register, with the frame update in between. Configuration
// writes on cfg are taken at once and should be made while no request is in flight.
module obd_response_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	obdrfp_rx_if.sink   rx,
	obdrfp_res_if.source parsed,
	obdrfp_cfg_if.sink  cfg
);

	logic                         valid_s1;
	logic                         command_s1;
	logic [obdrfp_pkg::ByteW-1:0] data_byte_s1;
	logic                         valid_s2;
	obdrfp_pkg::result_t          res_s2;

	obdrfp_pkg::cfg_t    cfg_regs;
	obdrfp_pkg::result_t res_comb;
	logic                advance;

	obdrfp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// Move the held request on when it is a tick or the result slot frees up
	assign advance  = valid_s1 && (command_s1 == obdrfp_pkg::CmdTick || !valid_s2 || parsed.ready);
	assign rx.ready = !valid_s1 || advance;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			command_s1   <= rx.command;
			data_byte_s1 <= rx.data_byte;
		end
	end

	obdrfp_frame_core u_frame_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.command   (command_s1),
		.data_byte (data_byte_s1),
		.cfg       (cfg_regs),
		.res       (res_comb)
	);

	// Load the result register on each byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && command_s1 == obdrfp_pkg::CmdByte) begin
			valid_s2 <= 1'b1;
		end else if (parsed.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && command_s1 == obdrfp_pkg::CmdByte) begin
			res_s2 <= res_comb;
		end
	end

	assign parsed.valid         = valid_s2;
	assign parsed.frame_byte    = res_s2.frame_byte;
	assign parsed.position      = res_s2.position;
	assign parsed.frame_end     = res_s2.frame_end;
	assign parsed.checksum_ok   = res_s2.checksum_ok;
	assign parsed.service_match = res_s2.service_match;
	assign parsed.pid           = res_s2.pid;
	assign parsed.frame_length  = res_s2.frame_length;
	assign parsed.restarted     = res_s2.restarted;

endmodule

// ===== tb/tb_obd_response_frame_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_obd_response_frame_parser_unit;

	localparam int ByteW      = obdrfp_pkg::ByteW;
	localparam int PosW       = obdrfp_pkg::PosW;
	localparam int LenFieldW  = obdrfp_pkg::LenFieldW;
	localparam int GapW       = obdrfp_pkg::GapW;
	localparam int CfgIdxW    = obdrfp_pkg::CfgIdxW;
	localparam int CfgDataW   = obdrfp_pkg::CfgDataW;

	localparam int DrainCycles = 8;
	localparam int PhaseItems  = 300;
	localparam int PhaseCount  = 6;

	// Frame predictor and store of expected parsed bytes
	class parser_scoreboard;
		logic [GapW-1:0]      timeout_ticks;
		logic [ByteW-1:0]     service_code;
		logic                 in_body;
		logic [PosW-1:0]      byte_count;
		logic [ByteW-1:0]     byte_sum;
		logic [LenFieldW-1:0] len_field;
		logic [ByteW-1:0]     service_byte;
		logic [ByteW-1:0]     pid_byte;
		logic [GapW-1:0]      gap_count;
		obdrfp_pkg::result_t  expected_bytes[$];
		int                   errors;

		function new();
			timeout_ticks = obdrfp_pkg::GapTimeoutRst;
			service_code = obdrfp_pkg::MatchedServiceRst;
			clear_frame();
			gap_count = '0;
			errors = 0;
		endfunction

		function void clear_frame();
			in_body = 1'b0;
			byte_count = '0;
			byte_sum = '0;
			len_field = '0;
			service_byte = '0;
			pid_byte = '0;
		endfunction

		function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
			case (idx)
				obdrfp_pkg::CfgGapTimeout: timeout_ticks = value;
				obdrfp_pkg::CfgMatchedService: service_code = value[ByteW-1:0];
				default: ;
			endcase
		endfunction

		// Predict the parsed byte for one accepted request
		function void note_request(logic cmd, logic [ByteW-1:0] b);
			obdrfp_pkg::result_t r;
			logic [PosW-1:0]     pos;
			logic [PosW-1:0]     total;
			logic                done;
			if (cmd == obdrfp_pkg::CmdTick) begin
				if (gap_count != '1)
					gap_count++;
				return;
			end
			r = '0;
			// drop a partial frame after a long gap
			if (gap_count >= timeout_ticks) begin
				r.restarted = (byte_count != 0);
				clear_frame();
			end
			gap_count = '0;
			pos = byte_count;
			if (pos == 0)
				len_field = b[LenFieldW-1:0] & obdrfp_pkg::LenMask;
			else if (pos == obdrfp_pkg::SvcPos)
				service_byte = b;
			else if (pos == obdrfp_pkg::PidPos)
				pid_byte = b;
			total = {1'b0, len_field} + obdrfp_pkg::FrameOverhead;
			done = in_body && (pos + 7'd1 == total);
			r.frame_byte = b;
			r.position = pos;
			r.frame_end = done;
			r.checksum_ok = done && (b == byte_sum);
			r.service_match = r.checksum_ok && (service_byte == service_code);
			r.pid = pid_byte;
			r.frame_length = total;
			expected_bytes.push_back(r);
			// advance the frame
			if (done) begin
				clear_frame();
			end else begin
				byte_sum = byte_sum + b;
				byte_count = pos + 7'd1;
				if (byte_count >= obdrfp_pkg::HdrLen)
					in_body = 1'b1;
			end
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		// Check one parsed byte against the oldest prediction
		function void check_parsed(obdrfp_pkg::result_t got);
			obdrfp_pkg::result_t want;
			if (expected_bytes.size() == 0) begin
				$error("parsed byte %0d with no request pending", got.frame_byte);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			compare_field("frame_byte", want.frame_byte, got.frame_byte);
			compare_field("position", want.position, got.position);
			compare_field("frame_end", want.frame_end, got.frame_end);
			compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
			compare_field("service_match", want.service_match, got.service_match);
			compare_field("pid", want.pid, got.pid);
			compare_field("frame_length", want.frame_length, got.frame_length);
			compare_field("restarted", want.restarted, got.restarted);
		endfunction

		function int pending_count();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	obdrfp_rx_if  rx_ch ();
	obdrfp_res_if parsed_ch ();
	obdrfp_cfg_if cfg_ch ();

	obd_response_frame_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.parsed (parsed_ch),
		.cfg    (cfg_ch)
	);

	parser_scoreboard sb = new();

	int                  tx_idle_pct;
	int                  rx_stall_pct;
	logic                hold_parsed;
	int                  item_count;
	int                  cur_timeout;
	int                  cur_service;
	obdrfp_pkg::result_t seen;

	always #2 clk = ~clk;

	// Sample parsed bytes and drive ready with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			parsed_ch.ready <= 1'b0;
		end else begin
			if (parsed_ch.valid && parsed_ch.ready) begin
				seen.frame_byte = parsed_ch.frame_byte;
				seen.position = parsed_ch.position;
				seen.frame_end = parsed_ch.frame_end;
				seen.checksum_ok = parsed_ch.checksum_ok;
				seen.service_match = parsed_ch.service_match;
				seen.pid = parsed_ch.pid;
				seen.frame_length = parsed_ch.frame_length;
				seen.restarted = parsed_ch.restarted;
				sb.check_parsed(seen);
			end
			parsed_ch.ready <= !hold_parsed && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one request after a random idle gap and wait for it to be taken
	task automatic send_request(input logic cmd, input logic [ByteW-1:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.command <= cmd;
		rx_ch.data_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.note_request(cmd, b);
		item_count++;
	endtask

	task automatic send_ticks(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_request(obdrfp_pkg::CmdTick, ByteW'($urandom));
	endtask

	task automatic send_bytes(input logic [ByteW-1:0] bytes[$]);
		int k;
		for (k = 0; k < bytes.size(); k++)
			send_request(obdrfp_pkg::CmdByte, bytes[k]);
	endtask

	// Hold the sender until every parsed byte is back and the pipe is empty
	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_register(idx, value);
		if (idx == obdrfp_pkg::CfgGapTimeout)
			cur_timeout = value;
		else
			cur_service = value[ByteW-1:0];
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic hold_off_receiver(input int cycles);
		int n;
		hold_parsed <= 1'b1;
		for (n = 0; n < cycles; n++)
			@(posedge clk);
		hold_parsed <= 1'b0;
	endtask

	// Send one frame with random content, mostly with a correct checksum, now and then broken by a gap
	task automatic send_random_frame();
		int              len_f;
		int              total;
		int              i;
		int              lim;
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] running;
		len_f = ($urandom_range(15) == 0) ? $urandom_range(63) : $urandom_range(6);
		total = len_f + 4;
		lim = (cur_timeout + 2 > 40) ? 40 : cur_timeout + 2;
		if ($urandom_range(3) == 0)
			send_ticks($urandom_range(lim));
		running = '0;
		for (i = 0; i < total; i++) begin
			if (i == 0)
				b = {2'($urandom_range(3)), 6'(len_f)};
			else if (i == total - 1)
				b = ($urandom_range(9) < 8) ? running : ByteW'($urandom);
			else if (i == 3 && $urandom_range(1) == 0)
				b = ByteW'(cur_service);
			else
				b = ByteW'($urandom);
			send_request(obdrfp_pkg::CmdByte, b);
			running = running + b;
			if (i < total - 1 && $urandom_range(24) == 0)
				send_ticks($urandom_range(1, lim));
		end
	endtask

	initial begin
		int phase;
		int phase_end;
		bit paused;
		logic [ByteW-1:0] frame_q[$];

		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.command <= obdrfp_pkg::CmdByte;
		rx_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= obdrfp_pkg::CfgGapTimeout;
		cfg_ch.data <= '0;
		hold_parsed <= 1'b0;
		rx_stall_pct <= 0;
		tx_idle_pct = 0;
		item_count = 0;
		cur_timeout = obdrfp_pkg::GapTimeoutRst;
		cur_service = obdrfp_pkg::MatchedServiceRst;
		paused = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest frame: checksum byte is also the service byte
		frame_q = '{8'h00, 8'h20, 8'h21, 8'h41};
		send_bytes(frame_q);
		// five-byte frame, format flags set, pid is the checksum byte
		frame_q = '{8'hC1, 8'hFF, 8'h00, 8'h41, 8'h01};
		send_bytes(frame_q);
		// bad checksum
		frame_q = '{8'h00, 8'h00, 8'h00, 8'h7F};
		send_bytes(frame_q);
		// partial frame dropped by a timeout, then completed frame
		frame_q = '{8'h02, 8'h11, 8'h22};
		send_bytes(frame_q);
		send_ticks(20);
		frame_q = '{8'h80, 8'hFF, 8'h00, 8'h7F};
		send_bytes(frame_q);
		// timeout with nothing pending
		send_ticks(25);
		send_request(obdrfp_pkg::CmdByte, 8'h3F);
		send_request(obdrfp_pkg::CmdByte, 8'hFF);
		wait_drained();

		// zero timeout: every byte is late
		write_register(obdrfp_pkg::CfgGapTimeout, 16'h0000);
		write_register(obdrfp_pkg::CfgMatchedService, 16'h0000);
		frame_q = '{8'h12, 8'h34, 8'h56};
		send_bytes(frame_q);

		// random phases over settings and idle patterns
		for (phase = 0; phase < PhaseCount; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_register(obdrfp_pkg::CfgGapTimeout, obdrfp_pkg::GapTimeoutRst);
					write_register(obdrfp_pkg::CfgMatchedService,
						16'(obdrfp_pkg::MatchedServiceRst));
				end
				1: begin
					write_register(obdrfp_pkg::CfgGapTimeout, 16'd1);
					write_register(obdrfp_pkg::CfgMatchedService, 16'h0000);
				end
				2: begin
					write_register(obdrfp_pkg::CfgGapTimeout, 16'hFFFF);
					write_register(obdrfp_pkg::CfgMatchedService, 16'h00FF);
				end
				3: begin
					write_register(obdrfp_pkg::CfgGapTimeout, 16'($urandom_range(2, 30)));
					write_register(obdrfp_pkg::CfgMatchedService, 16'($urandom_range(255)));
				end
				4: begin
					write_register(obdrfp_pkg::CfgGapTimeout, 16'd3);
					write_register(obdrfp_pkg::CfgMatchedService,
						16'(obdrfp_pkg::MatchedServiceRst));
				end
				default: begin
					write_register(obdrfp_pkg::CfgGapTimeout, 16'($urandom_range(1, 50)));
					write_register(obdrfp_pkg::CfgMatchedService, 16'($urandom_range(255)));
				end
			endcase
			case (phase % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 77;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 77;
				end
				default: begin
					tx_idle_pct = 15;
					rx_stall_pct <= 15;
				end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (phase == 0) begin
				fork
					hold_off_receiver(400);
				join_none
			end
			phase_end = item_count + PhaseItems;
			while (item_count < phase_end) begin
				if ($urandom_range(9) == 0)
					send_request(1'($urandom_range(1)), ByteW'($urandom));
				else
					send_random_frame();
				// pause the sender until everything is back
				if (phase == 3 && !paused && item_count > phase_end - PhaseItems / 2) begin
					wait_drained();
					paused = 1;
				end
			end
		end

		wait_drained();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
